### rtl/stq_pkg.sv
package stq_pkg;

  localparam int unsigned NumTimers   = 32;
  localparam int unsigned NumChannels = 16;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_ALLOC = 3'd1,
    CMD_FREE  = 3'd2,
    CMD_INIT  = 3'd3,
    CMD_SET   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLOSED = 2'd0,
    ST_ALLOC  = 2'd1,
    ST_RUN    = 2'd2
  } slot_state_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NO_FREE = 2'd1,
    STS_BAD     = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    FSM_IDLE,
    FSM_ALLOC_SCAN,
    FSM_INS_RD,
    FSM_INS_OD,
    FSM_INS_CMP,
    FSM_INS_DONE,
    FSM_CNT_RD,
    FSM_CNT_OD,
    FSM_CNT_CMP,
    FSM_EMIT_RD,
    FSM_EMIT_LD,
    FSM_SHIFT_RD,
    FSM_SHIFT_WR,
    FSM_HEAD_RD,
    FSM_HEAD_DL,
    FSM_HEAD_SET,
    FSM_ACK
  } fsm_e;

  localparam logic [31:0] AllOnes = 32'hffff_ffff;
  localparam int unsigned MaxOut = 32;

endpackage

### rtl/stq_ctrl.sv
module stq_ctrl
  import stq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [79:0] s_tdata_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [42:0] m_tdata_o,
  output logic        m_tlast_o,
  output logic        m_tuser_o
);

  localparam int unsigned IW = $clog2(NumTimers);
  localparam int unsigned CW = $clog2(NumTimers + 1);

  fsm_e state_q, state_d;

  logic [2:0]  cmd_q, cmd_d;
  logic [4:0]  idx_q, idx_d;
  logic [31:0] tick_q, tick_d;
  logic [31:0] nextdl_q, nextdl_d;
  logic [CW-1:0] act_q, act_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] n_q, n_d;
  logic [31:0] when_q, when_d;
  logic [IW-1:0] cur_q, cur_d;

  logic [1:0]  sstate_q [NumTimers];
  logic [3:0]  sdest_q  [NumTimers];
  logic [31:0] spay_q   [NumTimers];

  // Order list and deadline memories, one write and one registered read port each.
  logic [IW-1:0] ord_mem [NumTimers];
  logic [31:0]   dl_mem  [NumTimers];
  logic          ord_we, dl_we;
  logic [IW-1:0] ord_wa, ord_ra, dl_wa, dl_ra;
  logic [IW-1:0] ord_wd, ord_rd_q;
  logic [31:0]   dl_wd, dl_rd_q;

  always_ff @(posedge clk_i) begin
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    ord_rd_q <= ord_mem[ord_ra];
    if (dl_we) dl_mem[dl_wa] <= dl_wd;
    dl_rd_q <= dl_mem[dl_ra];
  end

  // Result register.
  logic        ov_q, ov_d;
  logic        okind_q, okind_d, olast_q, olast_d;
  logic [4:0]  oslot_q, oslot_d;
  logic [3:0]  odest_q, odest_d;
  logic [31:0] opay_q, opay_d;
  logic [1:0]  osts_q, osts_d;

  logic        st_we;
  logic [IW-1:0] st_wa;
  logic [1:0]  st_wd;
  logic        pl_we;

  logic [2:0]  in_cmd;
  logic [4:0]  in_idx;
  logic [3:0]  in_chan;
  logic [31:0] in_data, in_dly;
  logic        in_ok_idx;
  logic        out_free;
  logic [CW-1:0] ptr_inc;

  // Shared deadline comparator.
  logic [31:0] tick_inc;
  logic [31:0] cmp_a, cmp_b;
  logic        a_gt_b;

  assign in_cmd  = s_tdata_i[2:0];
  assign in_idx  = s_tdata_i[7:3];
  assign in_chan = s_tdata_i[11:8];
  assign in_data = s_tdata_i[43:12];
  assign in_dly  = s_tdata_i[75:44];
  assign in_ok_idx = {27'd0, in_idx} < NumTimers;
  assign out_free = !ov_q || m_tready_i;
  assign ptr_inc  = ptr_q + CW'(1);

  assign tick_inc = tick_q + 32'd1;
  assign cmp_a  = (state_q == FSM_IDLE) ? nextdl_q : dl_rd_q;
  assign cmp_b  = (state_q == FSM_IDLE) ? tick_inc :
                  ((state_q == FSM_INS_CMP) ? when_q : tick_q);
  assign a_gt_b = cmp_a > cmp_b;

  assign s_tready_o = (state_q == FSM_IDLE) && out_free;
  assign m_tvalid_o = ov_q;
  // slot, dest, payload, status from bit 0 up
  assign m_tdata_o  = {osts_q, opay_q, odest_q, oslot_q};
  assign m_tlast_o  = olast_q;
  assign m_tuser_o  = okind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_IDLE;
      tick_q   <= '0;
      nextdl_q <= AllOnes;
      act_q    <= '0;
      ov_q     <= 1'b0;
      for (int i = 0; i < NumTimers; i++) begin
        sstate_q[i] <= ST_CLOSED;
        sdest_q[i]  <= '0;
        spay_q[i]   <= '0;
      end
    end else begin
      state_q  <= state_d;
      tick_q   <= tick_d;
      nextdl_q <= nextdl_d;
      act_q    <= act_d;
      ov_q     <= ov_d;
      if (st_we) sstate_q[st_wa] <= st_wd;
      if (pl_we) begin
        sdest_q[in_idx[IW-1:0]] <= in_chan;
        spay_q[in_idx[IW-1:0]]  <= in_data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; idx_q <= idx_d;
    ptr_q <= ptr_d; n_q <= n_d; when_q <= when_d; cur_q <= cur_d;
    okind_q <= okind_d; olast_q <= olast_d; oslot_q <= oslot_d;
    odest_q <= odest_d; opay_q <= opay_d; osts_q <= osts_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q; idx_d = idx_q;
    tick_d = tick_q; nextdl_d = nextdl_q; act_d = act_q;
    ptr_d = ptr_q; n_d = n_q; when_d = when_q; cur_d = cur_q;
    ov_d = ov_q && !m_tready_i;
    okind_d = okind_q; olast_d = olast_q; oslot_d = oslot_q;
    odest_d = odest_q; opay_d = opay_q; osts_d = osts_q;
    ord_we = 1'b0; ord_wa = '0; ord_wd = '0; ord_ra = '0;
    dl_we = 1'b0; dl_wa = '0; dl_wd = '0; dl_ra = '0;
    st_we = 1'b0; st_wa = '0; st_wd = ST_CLOSED;
    pl_we = 1'b0;

    unique case (state_q)
      FSM_IDLE: begin
        if (s_tvalid_i && out_free) begin
          cmd_d = in_cmd; idx_d = in_idx;
          okind_d = 1'b0; olast_d = 1'b1; oslot_d = in_idx;
          odest_d = '0; opay_d = '0; osts_d = STS_BAD;
          ptr_d = '0;
          n_d = '0;
          state_d = FSM_ACK;
          unique case (in_cmd)
            CMD_TICK: begin
              // Skip the list walk while the head is not yet due.
              tick_d = tick_inc;
              state_d = a_gt_b ? FSM_IDLE : FSM_CNT_RD;
            end
            CMD_ALLOC: begin
              oslot_d = '0; osts_d = STS_NO_FREE;
              state_d = FSM_ALLOC_SCAN;
            end
            CMD_FREE: begin
              if (in_ok_idx && sstate_q[in_idx[IW-1:0]] != ST_RUN) begin
                st_we = 1'b1; st_wa = in_idx[IW-1:0]; st_wd = ST_CLOSED;
                osts_d = STS_OK;
              end
            end
            CMD_INIT: begin
              if (in_ok_idx && {28'd0, in_chan} < NumChannels) begin
                pl_we = 1'b1; osts_d = STS_OK;
              end
            end
            CMD_SET: begin
              if (in_ok_idx && sstate_q[in_idx[IW-1:0]] == ST_ALLOC
                  && act_q < CW'(NumTimers)) begin
                when_d = tick_q + in_dly;
                ptr_d = act_q;
                state_d = FSM_INS_RD;
              end
            end
            default: ;
          endcase
        end
      end
      FSM_ALLOC_SCAN: begin
        // Walk slots one per cycle for the lowest closed one.
        if (sstate_q[ptr_q[IW-1:0]] == ST_CLOSED) begin
          st_we = 1'b1; st_wa = ptr_q[IW-1:0]; st_wd = ST_ALLOC;
          oslot_d = 5'(ptr_q); osts_d = STS_OK;
          state_d = FSM_ACK;
        end else if (ptr_q == CW'(NumTimers - 1)) begin
          state_d = FSM_ACK;
        end else begin
          ptr_d = ptr_inc;
        end
      end
      FSM_INS_RD: begin
        // ptr is the hole; look at the entry just before it.
        if (ptr_q == '0) begin
          state_d = FSM_INS_DONE;
        end else begin
          ord_ra = IW'(ptr_q - CW'(1));
          state_d = FSM_INS_OD;
        end
      end
      FSM_INS_OD: begin
        dl_ra = ord_rd_q;
        cur_d = ord_rd_q;
        state_d = FSM_INS_CMP;
      end
      FSM_INS_CMP: begin
        // Move a later entry up one place; ties stay ahead of the new one.
        if (a_gt_b) begin
          ord_we = 1'b1; ord_wa = ptr_q[IW-1:0]; ord_wd = cur_q;
          ptr_d = ptr_q - CW'(1);
          state_d = FSM_INS_RD;
        end else begin
          state_d = FSM_INS_DONE;
        end
      end
      FSM_INS_DONE: begin
        ord_we = 1'b1; ord_wa = ptr_q[IW-1:0]; ord_wd = idx_q[IW-1:0];
        dl_we = 1'b1; dl_wa = idx_q[IW-1:0]; dl_wd = when_q;
        st_we = 1'b1; st_wa = idx_q[IW-1:0]; st_wd = ST_RUN;
        act_d = act_q + CW'(1);
        osts_d = STS_OK;
        state_d = FSM_HEAD_RD;
      end
      FSM_CNT_RD: begin
        // Count the due prefix first so the final expiry can carry last.
        if (n_q == act_q || n_q == CW'(MaxOut)) begin
          ptr_d = '0;
          state_d = (n_q == '0) ? FSM_IDLE : FSM_EMIT_RD;
        end else begin
          ord_ra = n_q[IW-1:0];
          state_d = FSM_CNT_OD;
        end
      end
      FSM_CNT_OD: begin
        dl_ra = ord_rd_q;
        state_d = FSM_CNT_CMP;
      end
      FSM_CNT_CMP: begin
        if (a_gt_b) begin
          ptr_d = '0;
          state_d = (n_q == '0) ? FSM_IDLE : FSM_EMIT_RD;
        end else begin
          n_d = n_q + CW'(1);
          state_d = FSM_CNT_RD;
        end
      end
      FSM_EMIT_RD: begin
        ord_ra = ptr_q[IW-1:0];
        state_d = FSM_EMIT_LD;
      end
      FSM_EMIT_LD: begin
        // Hold the read address so the slot stays valid across a stall.
        ord_ra = ptr_q[IW-1:0];
        if (out_free) begin
          ov_d = 1'b1;
          okind_d = 1'b1; oslot_d = ord_rd_q; odest_d = sdest_q[ord_rd_q];
          opay_d = spay_q[ord_rd_q]; osts_d = STS_OK;
          olast_d = (ptr_inc == n_q);
          st_we = 1'b1; st_wa = ord_rd_q; st_wd = ST_ALLOC;
          if (ptr_inc == n_q) begin
            ptr_d = '0;
            state_d = FSM_SHIFT_RD;
          end else begin
            ptr_d = ptr_inc;
            state_d = FSM_EMIT_RD;
          end
        end
      end
      FSM_SHIFT_RD: begin
        if (ptr_q + n_q >= act_q) begin
          act_d = act_q - n_q;
          state_d = FSM_HEAD_RD;
        end else begin
          ord_ra = IW'(ptr_q + n_q);
          state_d = FSM_SHIFT_WR;
        end
      end
      FSM_SHIFT_WR: begin
        ord_we = 1'b1; ord_wa = ptr_q[IW-1:0]; ord_wd = ord_rd_q;
        ptr_d = ptr_inc;
        state_d = FSM_SHIFT_RD;
      end
      FSM_HEAD_RD: begin
        ord_ra = '0;
        state_d = FSM_HEAD_DL;
      end
      FSM_HEAD_DL: begin
        dl_ra = ord_rd_q;
        state_d = FSM_HEAD_SET;
      end
      FSM_HEAD_SET: begin
        nextdl_d = (act_q != '0) ? dl_rd_q : AllOnes;
        state_d = (cmd_q == CMD_SET) ? FSM_ACK : FSM_IDLE;
      end
      FSM_ACK: begin
        if (out_free) begin
          ov_d = 1'b1;
          olast_d = 1'b1;
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o |-> state_q == FSM_IDLE)
    else $error("ready outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q <= CW'(NumTimers))
    else $error("active count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> $stable(m_tdata_o))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> m_tvalid_o)
    else $error("result dropped while stalled");

endmodule

### rtl/sorted_timer_queue_unit.sv
// Sorted one-shot timer pool.
// Slave channel carries one command request per beat; master channel carries
// results: one acknowledge per command, or zero to 32 expiry events per tick,
// the final one flagged by m_axis_tlast. tuser is 0 for acknowledge, 1 expiry.
// Free, init and refused requests go straight to the acknowledge. Alloc scans
// the slots from 0 for the lowest closed one. Set-delay walks the sorted list
// from its tail, moving each later entry up one place, then places the entry
// and reloads the head deadline.
// A tick that is not yet due gives no result. A due tick first counts the due
// entries, then emits them, compacts the list over the surviving entries and
// reloads the head deadline.
// Each list step is a two-step order list / deadline lookup through one
// registered read port. One request is in work at a time; s_axis_tready
// is low until the sequencer is idle and the result register is free.
// Reset clears the tick counter, active count and all slot states, channels
// and payloads; list memories need no clearing.
// A stalled receiver holds the result register and the sequencer waits.
module sorted_timer_queue_unit
  import stq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[2:0], timer_index[7:3], channel[11:8], data_in[43:12], delay[75:44]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // slot[4:0], dest[8:5], payload[40:9], status[42:41]
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // kind
  output logic        m_axis_tuser
);

  logic [42:0] tdata;

  stq_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_o(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .m_tvalid_o(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_o(tdata),
    .m_tlast_o(m_axis_tlast), .m_tuser_o(m_axis_tuser)
  );

  // Pad result to whole bytes.
  assign m_axis_tdata = {5'd0, tdata};

endmodule
